// File: src/tbga_pkg.sv
// Shared widths, constants and pipeline payload types for the third-body acceleration block.
package tbga_pkg;

    localparam int POS_W      = 48;              // position component, 1/16 m
    localparam int MAG_W      = POS_W + 1;       // magnitude of a difference vector component
    localparam int SQ_W       = 2 * MAG_W;       // squared distance
    localparam int ROOT_W     = 50;              // floor(sqrt(r2))
    localparam int REM_W      = ROOT_W + 2;      // square root partial remainder
    localparam int DEN_W      = SQ_W + ROOT_W;   // r2 * r
    localparam int GM_W       = 50;
    localparam int NUM_W      = GM_W + MAG_W;    // gm * |v|
    localparam int NUM_SHIFT  = 56;              // 2^8 position scale times 2^48 output scale
    localparam int QUO_W      = 63;
    localparam int ACC_W      = 64;
    localparam int NVEC       = 6;               // d x,y,z then s x,y,z
    localparam int MUL_CHUNK  = 25;
    localparam int MUL_LAT    = 3;
    localparam int DIV_LAT    = QUO_W + 1;

    localparam logic [GM_W-1:0] GM_RESET = 50'd4902800066164;

    typedef struct packed {
        logic [NVEC-1:0]            neg;
        logic [NVEC-1:0][MAG_W-1:0] mag;
        logic [2:0][ACC_W-1:0]      sum_in;
    } side_t;

    typedef struct packed {
        logic [NVEC-1:0]       neg;
        logic                  ok;
        logic [2:0][ACC_W-1:0] sum_in;
    } tail_t;

endpackage

// File: src/third_body_gravity_accel_top.sv
// Third-body point-mass acceleration: top level pipeline.
// Usage: present one request on the s_ channel (two positions plus the running
// derivative sum); one result leaves on the m_ channel with acc = GM*(d/|d|^3 - s/|s|^3)
// and sum_out = sum_in + acc, both saturated to 64 bits. m_tuser flags a zero distance,
// in which case acc is zero and sum_out equals sum_in.
// cfg_we/cfg_wdata load body_gm; write it only while no request is in flight.
// Depth: 125 register stages from the s_ channel to the m_ channel.
// Throughput: one request per cycle unless the output stalls. The depth is set by the
// 50-step square root (one root bit per stage) and the 64-stage divider (overflow check,
// then one quotient bit per stage), plus multiplier and edge stages.
// Reset: body_gm returns to the lunar value, the pipeline empties, m_tvalid drops.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds and
// s_tready is low; nothing is lost or repeated. s_tready = !m_tvalid || m_tready.
module third_body_gravity_accel_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [49:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sat_x, sat_y, sat_z, body_x, body_y, body_z (48 b each), sum_in_x/y/z (64 b each)
    input  logic [479:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // acc_x, acc_y, acc_z, sum_out_x, sum_out_y, sum_out_z (64 b each)
    output logic [383:0] m_tdata,
    // degenerate
    output logic [0:0]   m_tuser
);
    import tbga_pkg::*;

    localparam int SQRT_STEPS = ROOT_W;
    localparam int SIDE_LEN   = MUL_LAT + 1 + SQRT_STEPS;
    localparam int TAIL_LEN   = MUL_LAT + DIV_LAT;
    localparam int LAT        = 2 + MUL_LAT + 1 + SQRT_STEPS + MUL_LAT + DIV_LAT + 2;

    function automatic logic [ACC_W-1:0] sat65(input logic [ACC_W:0] v);
        if (v[ACC_W] != v[ACC_W-1]) begin
            sat65 = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat65 = v[ACC_W-1:0];
        end
    endfunction

    logic             en;
    logic [LAT-1:0]   vld_reg;
    logic [GM_W-1:0]  gm_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            gm_reg  <= GM_RESET;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
            if (cfg_we) begin
                gm_reg <= cfg_wdata;
            end
        end
    end

    // stage 1: difference vector
    logic signed [MAG_W-1:0] d1_reg   [3];
    logic signed [POS_W-1:0] s1_reg   [3];
    logic [ACC_W-1:0]        sum1_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                d1_reg[i]   <= MAG_W'($signed(s_tdata[3*POS_W + i*POS_W +: POS_W]))
                             - MAG_W'($signed(s_tdata[i*POS_W +: POS_W]));
                s1_reg[i]   <= s_tdata[3*POS_W + i*POS_W +: POS_W];
                sum1_reg[i] <= s_tdata[6*POS_W + i*ACC_W +: ACC_W];
            end
        end
    end

    // stage 2: sign and magnitude
    side_t st2_reg;
    side_t st2_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            st2_next.neg[i]      = d1_reg[i][MAG_W-1];
            st2_next.mag[i]      = d1_reg[i][MAG_W-1] ? MAG_W'(-d1_reg[i]) : MAG_W'(d1_reg[i]);
            st2_next.neg[3+i]    = s1_reg[i][POS_W-1];
            st2_next.mag[3+i]    = s1_reg[i][POS_W-1] ? MAG_W'(-MAG_W'(s1_reg[i]))
                                                      : MAG_W'(s1_reg[i]);
            st2_next.sum_in[i]   = sum1_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st2_reg <= st2_next;
        end
    end

    // hold magnitudes, signs and sums until the denominators are ready
    side_t sd_reg [SIDE_LEN];

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= st2_reg;
            for (int k = 1; k < SIDE_LEN; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    // squares and squared distances
    logic [SQ_W-1:0] sq [NVEC];
    logic [SQ_W-1:0] r2_reg [2];

    genvar gi;
    generate
        for (gi = 0; gi < NVEC; gi++) begin : g_sq
            tbga_mul #(.AW(MAG_W), .BW(MAG_W)) u_sq (
                .aclk (aclk),
                .en   (en),
                .a    (st2_reg.mag[gi]),
                .b    (st2_reg.mag[gi]),
                .p    (sq[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int v = 0; v < 2; v++) begin
                r2_reg[v] <= sq[3*v] + sq[3*v+1] + sq[3*v+2];
            end
        end
    end

    // square root, one root bit per stage
    logic [REM_W-1:0]    sr_rem_reg  [2][SQRT_STEPS];
    logic [ROOT_W-1:0]   sr_root_reg [2][SQRT_STEPS];
    logic [SQ_W-1:0]     sr_r2_reg   [2][SQRT_STEPS];
    logic [REM_W-1:0]    sr_rem_in   [2][SQRT_STEPS];
    logic [ROOT_W-1:0]   sr_root_in  [2][SQRT_STEPS];
    logic [SQ_W-1:0]     sr_r2_in    [2][SQRT_STEPS];
    logic [2*ROOT_W-1:0] sr_pad      [2][SQRT_STEPS];
    logic [REM_W+1:0]    sr_cur      [2][SQRT_STEPS];
    logic [REM_W+1:0]    sr_trial    [2][SQRT_STEPS];
    logic                sr_ge       [2][SQRT_STEPS];

    always_comb begin
        for (int v = 0; v < 2; v++) begin
            for (int j = 0; j < SQRT_STEPS; j++) begin
                if (j == 0) begin
                    sr_rem_in[v][j]  = '0;
                    sr_root_in[v][j] = '0;
                    sr_r2_in[v][j]   = r2_reg[v];
                end else begin
                    sr_rem_in[v][j]  = sr_rem_reg[v][j-1];
                    sr_root_in[v][j] = sr_root_reg[v][j-1];
                    sr_r2_in[v][j]   = sr_r2_reg[v][j-1];
                end
                sr_pad[v][j]   = (2*ROOT_W)'(sr_r2_in[v][j]);
                sr_cur[v][j]   = {sr_rem_in[v][j], sr_pad[v][j][2*(SQRT_STEPS-1-j) +: 2]};
                sr_trial[v][j] = (REM_W+2)'({sr_root_in[v][j], 2'b01});
                sr_ge[v][j]    = sr_cur[v][j] >= sr_trial[v][j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int v = 0; v < 2; v++) begin
                for (int j = 0; j < SQRT_STEPS; j++) begin
                    sr_rem_reg[v][j]  <= sr_ge[v][j]
                                       ? REM_W'(sr_cur[v][j] - sr_trial[v][j])
                                       : REM_W'(sr_cur[v][j]);
                    sr_root_reg[v][j] <= {sr_root_in[v][j][ROOT_W-2:0], sr_ge[v][j]};
                    sr_r2_reg[v][j]   <= sr_r2_in[v][j];
                end
            end
        end
    end

    // denominators r2 * r and numerators gm * |v|
    logic [DEN_W-1:0] den [2];
    logic [NUM_W-1:0] num [NVEC];
    logic [QUO_W-1:0] quo [NVEC];

    generate
        for (gi = 0; gi < 2; gi++) begin : g_den
            tbga_mul #(.AW(SQ_W), .BW(ROOT_W)) u_den (
                .aclk (aclk),
                .en   (en),
                .a    (sr_r2_reg[gi][SQRT_STEPS-1]),
                .b    (sr_root_reg[gi][SQRT_STEPS-1]),
                .p    (den[gi])
            );
        end
        for (gi = 0; gi < NVEC; gi++) begin : g_num
            tbga_mul #(.AW(GM_W), .BW(MAG_W)) u_num (
                .aclk (aclk),
                .en   (en),
                .a    (gm_reg),
                .b    (sd_reg[SIDE_LEN-1].mag[gi]),
                .p    (num[gi])
            );
            tbga_div u_div (
                .aclk (aclk),
                .en   (en),
                .num  (num[gi]),
                .den  ((gi < 3) ? den[0] : den[1]),
                .quo  (quo[gi])
            );
        end
    endgenerate

    // hold signs, zero-distance flag and sums alongside the dividers
    tail_t tl_reg [TAIL_LEN];
    tail_t tl_next;

    always_comb begin
        tl_next.neg    = sd_reg[SIDE_LEN-1].neg;
        tl_next.sum_in = sd_reg[SIDE_LEN-1].sum_in;
        tl_next.ok     = (sr_r2_reg[0][SQRT_STEPS-1] != '0)
                      && (sr_r2_reg[1][SQRT_STEPS-1] != '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tl_reg[0] <= tl_next;
            for (int k = 1; k < TAIL_LEN; k++) begin
                tl_reg[k] <= tl_reg[k-1];
            end
        end
    end

    // acceleration, then derivative sum
    logic [ACC_W:0]   term  [NVEC];
    logic [ACC_W:0]   diff  [3];
    logic [ACC_W-1:0] acc_reg [3];
    logic [ACC_W-1:0] sum4_reg [3];
    logic             ok4_reg;
    logic [ACC_W-1:0] out_acc_reg [3];
    logic [ACC_W-1:0] out_sum_reg [3];
    logic             out_deg_reg;

    always_comb begin
        for (int i = 0; i < NVEC; i++) begin
            term[i] = tl_reg[TAIL_LEN-1].neg[i] ? (ACC_W+1)'(-(ACC_W+1)'(quo[i]))
                                                : (ACC_W+1)'(quo[i]);
        end
        for (int i = 0; i < 3; i++) begin
            diff[i] = term[i] - term[3+i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok4_reg <= tl_reg[TAIL_LEN-1].ok;
            for (int i = 0; i < 3; i++) begin
                acc_reg[i]  <= tl_reg[TAIL_LEN-1].ok ? sat65(diff[i]) : '0;
                sum4_reg[i] <= tl_reg[TAIL_LEN-1].sum_in[i];
            end
            out_deg_reg <= !ok4_reg;
            for (int i = 0; i < 3; i++) begin
                out_acc_reg[i] <= acc_reg[i];
                out_sum_reg[i] <= sat65({sum4_reg[i][ACC_W-1], sum4_reg[i]}
                                      + {acc_reg[i][ACC_W-1], acc_reg[i]});
            end
        end
    end

    assign m_tdata = {out_sum_reg[2], out_sum_reg[1], out_sum_reg[0],
                      out_acc_reg[2], out_acc_reg[1], out_acc_reg[0]};
    assign m_tuser = out_deg_reg;

endmodule

// File: src/tbga_mul.sv
// Pipelined unsigned multiplier: registers 25x25 partial products, row sums, p.
module tbga_mul #(
    parameter int AW = 49,
    parameter int BW = 49
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [AW-1:0]     a,
    input  logic [BW-1:0]     b,
    output logic [AW+BW-1:0]  p
);
    import tbga_pkg::*;

    localparam int CW = MUL_CHUNK;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int RW = (NB + 1) * CW;
    localparam int PW = (NA + NB) * CW;

    logic [NA*CW-1:0] ap;
    logic [NB*CW-1:0] bp;
    logic [2*CW-1:0]  pp_reg   [NA][NB];
    logic [RW-1:0]    row_next [NA];
    logic [RW-1:0]    row_reg  [NA];
    logic [PW-1:0]    p_next;
    logic [AW+BW-1:0] p_reg;

    assign ap = (NA*CW)'(a);
    assign bp = (NB*CW)'(b);

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++) begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (j * CW));
            end
        end
        p_next = '0;
        for (int i = 0; i < NA; i++) begin
            p_next = p_next + (PW'(row_reg[i]) << (i * CW));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= ap[i*CW +: CW] * bp[j*CW +: CW];
                end
                row_reg[i] <= row_next[i];
            end
            p_reg <= p_next[AW+BW-1:0];
        end
    end

    assign p = p_reg;

endmodule

// File: src/tbga_div.sv
// Pipelined restoring divider: floor(num * 2^56 / den), clamped to 2^63 - 1.
module tbga_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [tbga_pkg::NUM_W-1:0]  num,
    input  logic [tbga_pkg::DEN_W-1:0]  den,
    output logic [tbga_pkg::QUO_W-1:0]  quo
);
    import tbga_pkg::*;

    localparam int RW = DEN_W + QUO_W + 1;

    logic [RW-1:0]    rem_reg   [QUO_W+1];
    logic [DEN_W-1:0] den_reg   [QUO_W+1];
    logic [QUO_W-1:0] q_reg     [QUO_W+1];
    logic             clamp_reg [QUO_W+1];

    logic [RW-1:0]    rem_next  [QUO_W+1];
    logic [QUO_W-1:0] q_next    [QUO_W+1];
    logic [RW-1:0]    sub       [QUO_W+1];
    logic             ge        [QUO_W+1];
    logic [RW-1:0]    num_sh;

    always_comb begin
        num_sh      = RW'(num) << NUM_SHIFT;
        sub[0]      = RW'(den) << QUO_W;
        ge[0]       = num_sh >= sub[0];
        rem_next[0] = num_sh;
        q_next[0]   = '0;
        for (int s = 1; s <= QUO_W; s++) begin
            sub[s]      = RW'(den_reg[s-1]) << (QUO_W - s);
            ge[s]       = rem_reg[s-1] >= sub[s];
            rem_next[s] = ge[s] ? rem_reg[s-1] - sub[s] : rem_reg[s-1];
            q_next[s]   = q_reg[s-1] | (ge[s] ? (QUO_W'(1) << (QUO_W - s)) : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]   <= rem_next[0];
            den_reg[0]   <= den;
            q_reg[0]     <= q_next[0];
            clamp_reg[0] <= ge[0];
            for (int s = 1; s <= QUO_W; s++) begin
                rem_reg[s]   <= rem_next[s];
                den_reg[s]   <= den_reg[s-1];
                q_reg[s]     <= q_next[s];
                clamp_reg[s] <= clamp_reg[s-1];
            end
        end
    end

    assign quo = clamp_reg[QUO_W] ? '1 : q_reg[QUO_W];

endmodule

// File: src/tbga_chk.sv
// Port-level checker for the third-body acceleration block, bound to the top level.
module tbga_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [383:0] m_tdata,
    input logic [0:0]   m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[191:0] == 192'd0)
        else $error("degenerate result carries nonzero acceleration");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind third_body_gravity_accel_top tbga_chk u_tbga_chk (.*);

// File: verif/third_body_gravity_accel_top_tb.sv
// Self-checking testbench for the third-body acceleration pipeline.
`timescale 1ns / 1ps

module third_body_gravity_accel_top_tb;
    import tbga_pkg::*;

    localparam logic signed [65:0] S64_MAX = 66'sd9223372036854775807;
    localparam logic signed [65:0] S64_MIN = -S64_MAX - 66'sd1;
    localparam logic [255:0] QUO_MAX = 256'h7FFF_FFFF_FFFF_FFFF;
    localparam int DRAIN_CYCLES = 140;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [49:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [479:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [383:0] m_tdata;
    logic [0:0]   m_tuser;

    logic [479:0] pending_reqs[$];
    logic [384:0] accel_expected[$];
    logic [49:0]  gm_model;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           reqs_queued;
    int           reqs_accepted;
    int           mismatches;

    third_body_gravity_accel_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // r2 * floor(sqrt(r2)) for one vector, zero for the zero vector
    function automatic logic [255:0] cube_dist(logic [48:0] mx, logic [48:0] my,
                                               logic [48:0] mz);
        logic [255:0] r2;
        logic [255:0] root;
        logic [255:0] trial;
        r2 = 256'(mx) * 256'(mx) + 256'(my) * 256'(my) + 256'(mz) * 256'(mz);
        root = '0;
        for (int b = 49; b >= 0; b--) begin
            trial = root | (256'd1 << b);
            if (trial * trial <= r2) root = trial;
        end
        return r2 * root;
    endfunction

    function automatic logic signed [65:0] grav_term(logic neg, logic [48:0] mag,
                                                     logic [255:0] den, logic [49:0] gm);
        logic [255:0] quo;
        logic signed [65:0] val;
        quo = ((256'(gm) * 256'(mag)) << NUM_SHIFT) / den;
        if (quo > QUO_MAX) quo = QUO_MAX;
        val = $signed({2'b00, quo[63:0]});
        return neg ? -val : val;
    endfunction

    function automatic logic [63:0] clamp64(logic signed [65:0] x);
        if (x > S64_MAX) return S64_MAX[63:0];
        if (x < S64_MIN) return S64_MIN[63:0];
        return x[63:0];
    endfunction

    // {degenerate, sum_out z..x, acc z..x}
    function automatic logic [384:0] predict_accel(logic [479:0] req, logic [49:0] gm);
        logic signed [48:0] dv[3];
        logic signed [48:0] sv[3];
        logic [48:0]        dm[3];
        logic [48:0]        sm[3];
        logic [255:0]       dden;
        logic [255:0]       sden;
        logic signed [65:0] acc;
        logic signed [65:0] sum_in;
        logic [383:0]       res;
        logic               ok;
        for (int i = 0; i < 3; i++) begin
            sv[i] = $signed(req[144 + 48*i +: 48]);
            dv[i] = sv[i] - $signed(req[48*i +: 48]);
            dm[i] = dv[i] < 0 ? -dv[i] : dv[i];
            sm[i] = sv[i] < 0 ? -sv[i] : sv[i];
        end
        dden = cube_dist(dm[0], dm[1], dm[2]);
        sden = cube_dist(sm[0], sm[1], sm[2]);
        ok = (dden != 0) && (sden != 0);
        for (int i = 0; i < 3; i++) begin
            acc = '0;
            if (ok)
                acc = $signed({2'b00, clamp64(grav_term(dv[i] < 0, dm[i], dden, gm)
                                              - grav_term(sv[i] < 0, sm[i], sden, gm))});
            acc = $signed({{2{acc[63]}}, acc[63:0]});
            sum_in = $signed(req[288 + 64*i +: 64]);
            res[64*i +: 64] = acc[63:0];
            res[192 + 64*i +: 64] = clamp64(sum_in + acc);
        end
        return {~ok, res};
    endfunction

    function automatic logic [47:0] rand_pos();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3, 0))
            0: return v[47:0];
            1: return $signed(v[47:0]) >>> $urandom_range(47, 1);
            2: return $signed(v[47:0]) >>> $urandom_range(47, 30);
            default: return $signed(v[47:0]) >>> $urandom_range(20, 8);
        endcase
    endfunction

    function automatic logic [63:0] rand_sum();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(2, 0))
            0: return v;
            1: return $signed(v) >>> $urandom_range(63, 1);
            default: return v[63] ? {1'b1, 63'd0} + v[7:0] : {1'b0, {63{1'b1}}} - v[7:0];
        endcase
    endfunction

    task automatic push_req(logic [47:0] sx, logic [47:0] sy, logic [47:0] sz,
                            logic [47:0] bx, logic [47:0] by, logic [47:0] bz,
                            logic [63:0] ux, logic [63:0] uy, logic [63:0] uz);
        pending_reqs.push_back({uz, uy, ux, bz, by, bx, sz, sy, sx});
        reqs_queued++;
    endtask

    task automatic push_random(int count);
        logic [47:0] sat[3];
        logic [47:0] bod[3];
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 3; i++) begin
                sat[i] = rand_pos();
                bod[i] = rand_pos();
            end
            // often place the spacecraft close to the body for large direct terms
            if ($urandom_range(2, 0) == 0)
                for (int i = 0; i < 3; i++)
                    bod[i] = sat[i] + ($signed(rand_pos()) >>> $urandom_range(47, 20));
            if ($urandom_range(30, 0) == 0) bod = sat;
            if ($urandom_range(30, 0) == 0) bod = '{48'd0, 48'd0, 48'd0};
            push_req(sat[0], sat[1], sat[2], bod[0], bod[1], bod[2],
                     rand_sum(), rand_sum(), rand_sum());
        end
    endtask

    task automatic wait_drain();
        do @(posedge aclk);
        while (reqs_accepted != reqs_queued || accel_expected.size() != 0);
    endtask

    task automatic write_gm(logic [49:0] value);
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        gm_model = value;
    endtask

    // driver: present requests, record the expectation at acceptance
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                accel_expected.push_back(predict_accel(s_tdata, gm_model));
                reqs_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_reqs.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure and field-wise comparison
    always @(posedge aclk) begin
        logic [384:0] exp_res;
        if (aresetn) begin
            m_tready <= $urandom_range(99, 0) >= recv_stall_pct;
            if (m_tvalid && m_tready) begin
                if (accel_expected.size() == 0) begin
                    $display("%0t: unexpected result data=%h deg=%b", $realtime, m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    exp_res = accel_expected.pop_front();
                    for (int f = 0; f < 6; f++)
                        if (m_tdata[64*f +: 64] !== exp_res[64*f +: 64]) begin
                            $display("%0t: field %0d expected %h actual %h", $realtime, f,
                                     exp_res[64*f +: 64], m_tdata[64*f +: 64]);
                            mismatches++;
                        end
                    if (m_tuser[0] !== exp_res[384]) begin
                        $display("%0t: degenerate expected %b actual %b", $realtime,
                                 exp_res[384], m_tuser[0]);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [47:0] pmax;
        logic [47:0] pmin;
        logic [63:0] smax;
        logic [63:0] smin;
        pmax = {1'b0, {47{1'b1}}};
        pmin = {1'b1, 47'd0};
        smax = {1'b0, {63{1'b1}}};
        smin = {1'b1, 63'd0};
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        gm_model = GM_RESET;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        reqs_queued = 0;
        reqs_accepted = 0;
        mismatches = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // zero vectors, coincident positions, extremes, tiny distances, sum saturation
        push_req(48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, smax, smin, 64'd5);
        push_req(48'd100, 48'd7, -48'd3, 48'd100, 48'd7, -48'd3, 64'd1, 64'd2, 64'd3);
        push_req(48'd100, 48'd7, -48'd3, 48'd0, 48'd0, 48'd0, smin, smax, 64'd0);
        push_req(pmin, pmin, pmin, pmax, pmax, pmax, 64'd0, 64'd0, 64'd0);
        push_req(pmax, pmax, pmax, pmin, pmin, pmin, smax, smin, 64'd0);
        push_req(pmax, 48'd0, 48'd0, pmin, 48'd0, 48'd0, 64'd0, 64'd0, 64'd0);
        push_req(48'd0, 48'd0, 48'd0, pmax, pmax, pmax, 64'd0, 64'd0, 64'd0);
        push_req(48'd0, 48'd0, 48'd0, 48'd1, 48'd0, 48'd0, smax, smin, 64'd0);
        push_req(48'd1, 48'd0, 48'd0, 48'd0, 48'd1, 48'd0, smin, smax, 64'd0);
        push_req(pmax, pmax, pmax, pmax - 48'd1, pmax, pmax, smax, smin, smax);
        push_req(pmin, pmin, pmin, pmin + 48'd1, pmin, pmin, smin, smax, smin);
        push_req(-48'd1, -48'd1, -48'd1, 48'd1, 48'd1, 48'd1, 64'd0, 64'd0, 64'd0);
        push_req(48'd5000, -48'd800, 48'd1, 48'd400000, 48'd300000, -48'd200000,
                 smax, smin, 64'd12345);
        push_req(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hF0F0_F0F0_F0F0,
                 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h0F0F_0F0F_0F0F,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, smax);
        push_random(330);
        wait_drain();

        write_gm({50{1'b1}});
        send_idle_pct = 85;
        push_random(180);
        // stop sending until everything in flight has come back
        wait_drain();
        push_random(180);
        wait_drain();

        write_gm(50'd0);
        send_idle_pct = 0;
        recv_stall_pct = 85;
        push_random(200);
        wait_drain();

        write_gm(50'({$urandom, $urandom}));
        send_idle_pct = 25;
        recv_stall_pct = 25;
        push_random(420);
        wait_drain();

        write_gm(GM_RESET);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        push_random(420);
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && accel_expected.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: third_body_gravity_accel_top.f
src/tbga_pkg.sv
src/tbga_mul.sv
src/tbga_div.sv
src/third_body_gravity_accel_top.sv
src/tbga_chk.sv
verif/third_body_gravity_accel_top_tb.sv
